[src/hvac_pkg.sv]
// package: shared types, constants and codes of the thermostat controller
package hvac_pkg;

	localparam int TEMP_WIDTH = 12;
	localparam int THR_WIDTH = 8;
	localparam int FAN_WIDTH = 2;

	localparam logic [THR_WIDTH-1:0] ACTIVE_THR_RESET = THR_WIDTH'(8);
	localparam logic [THR_WIDTH-1:0] INACTIVE_THR_RESET = THR_WIDTH'(24);

	localparam logic [FAN_WIDTH-1:0] FAN_OFF = FAN_WIDTH'(0);
	localparam logic [FAN_WIDTH-1:0] FAN_LOW = FAN_WIDTH'(1);
	localparam logic [FAN_WIDTH-1:0] FAN_HIGH = FAN_WIDTH'(2);

	typedef enum logic [0:0] {
		CFG_ACTIVE_THR = 1'b0,
		CFG_INACTIVE_THR = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_HEAT = 2'd1,
		MODE_COOL = 2'd2
	} mode_t;

	typedef logic signed [TEMP_WIDTH-1:0] temp_t;

	typedef struct packed {
		logic power_button_level;
		logic fan_button_level;
		logic remote_fan_valid;
		logic [FAN_WIDTH-1:0] remote_fan_speed;
		logic sample_valid;
		temp_t sample_temperature;
		logic setpoint_valid;
		temp_t setpoint_temperature;
	} item_t;

	typedef struct packed {
		logic [FAN_WIDTH-1:0] fan_speed;
		logic system_on;
		mode_t climate_mode;
		logic fan_changed;
		logic mode_changed;
		temp_t current_setpoint;
		temp_t current_temperature;
	} result_t;

	typedef struct packed {
		mode_t mode;
		logic changed;
	} eval_t;

endpackage

[src/hvac_mode_eval.sv]
// hysteresis mode evaluation: off, heat and cool transitions for one event
module hvac_mode_eval (
	input  logic active,
	input  hvac_pkg::mode_t mode_in,
	input  hvac_pkg::temp_t temp,
	input  hvac_pkg::temp_t target,
	input  logic [hvac_pkg::THR_WIDTH-1:0] active_thr,
	input  logic [hvac_pkg::THR_WIDTH-1:0] inactive_thr,
	output hvac_pkg::eval_t result
);
	import hvac_pkg::*;

	localparam int CW = TEMP_WIDTH + 2;

	logic signed [CW-1:0] temp_w;
	logic signed [CW-1:0] target_w;
	logic signed [CW-1:0] act_w;
	logic signed [CW-1:0] inact_w;
	logic heat_start;
	logic cool_start;
	logic heat_stop;
	logic cool_stop;
	mode_t off_mode;

	assign temp_w = {{2{temp[TEMP_WIDTH-1]}}, temp};
	assign target_w = {{2{target[TEMP_WIDTH-1]}}, target};
	assign act_w = {{(CW-THR_WIDTH){1'b0}}, active_thr};
	assign inact_w = {{(CW-THR_WIDTH){1'b0}}, inactive_thr};

	assign heat_start = (temp_w + inact_w) < target_w;
	assign cool_start = (temp_w - inact_w) > target_w;
	assign cool_stop = (temp_w + act_w) < target_w;
	assign heat_stop = (temp_w - act_w) > target_w;

	always_comb begin
		if (heat_start) begin
			off_mode = MODE_HEAT;
		end else if (cool_start) begin
			off_mode = MODE_COOL;
		end else begin
			off_mode = MODE_OFF;
		end
	end

	always_comb begin
		result.mode = mode_in;
		result.changed = 1'b0;
		if (active) begin
			case (mode_in)
				MODE_OFF: begin
					result.mode = off_mode;
					result.changed = heat_start | cool_start;
				end
				MODE_COOL: begin
					if (cool_stop) begin
						result.mode = off_mode;
						result.changed = 1'b1;
					end
				end
				MODE_HEAT: begin
					if (heat_stop) begin
						result.mode = off_mode;
						result.changed = 1'b1;
					end
				end
				default: begin
					result.mode = mode_in;
					result.changed = 1'b0;
				end
			endcase
		end
	end

endmodule

[src/hvac_thermostat_controller.sv]
// top level: thermostat controller with fan, power switch and hysteresis climate control
//
// Takes one poll transaction per clock while in_stall is low and returns one
// result transaction per poll: the poll is held in the input register, then the
// whole pass (button release detection, fan, remote fan, power, sample and
// setpoint with up to three chained hysteresis evaluations) is settled
// combinationally into the output register. Throughput is one transaction per
// cycle while out_stall is low; the input register and the output register both
// hold a transaction when the output side stalls. The first poll after reset only
// seeds setpoint and temperature from a present sample. Threshold registers are
// written through the configuration channel, which is always ready.
module hvac_thermostat_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  hvac_pkg::item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output hvac_pkg::result_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  hvac_pkg::cfg_index_t cfg_index,
	input  logic [hvac_pkg::THR_WIDTH-1:0] cfg_data
);
	import hvac_pkg::*;

	logic [THR_WIDTH-1:0] active_thr_q;
	logic [THR_WIDTH-1:0] inactive_thr_q;

	logic seeded_q;
	logic power_held_q;
	logic fan_held_q;
	logic [FAN_WIDTH-1:0] fan_q;
	logic [FAN_WIDTH-1:0] fan_saved_q;
	logic active_q;
	mode_t mode_q;
	temp_t target_q;
	temp_t temp_q;

	item_t in_s1;
	logic valid_s1;
	result_t out_q;
	logic out_valid_q;

	logic out_free;
	logic advance;

	logic fan_rel;
	logic power_rel;
	logic act_a;
	logic [FAN_WIDTH-1:0] fan_a;
	logic [FAN_WIDTH-1:0] saved_a;
	logic fchg_a;
	logic act_b;
	logic [FAN_WIDTH-1:0] fan_b;
	mode_t mode_b;
	logic fchg_b;
	logic mchg_b;
	temp_t temp_c;
	mode_t mode_c;
	logic mchg_c;
	temp_t target_d;
	mode_t mode_d;
	logic mchg_d;
	eval_t power_eval;
	eval_t sample_eval;
	eval_t setpoint_eval;
	result_t result_next;

	function automatic logic [FAN_WIDTH-1:0] fan_step(input logic [FAN_WIDTH-1:0] fan);
		logic [FAN_WIDTH-1:0] nxt;
		case (fan)
			FAN_OFF: nxt = FAN_LOW;
			FAN_LOW: nxt = FAN_HIGH;
			default: nxt = FAN_OFF;
		endcase
		return nxt;
	endfunction

	// handshake
	assign out_free = ~out_valid_q | ~out_stall;
	assign advance = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign cfg_ready = 1'b1;

	// fan button and remote fan
	always_comb begin
		fan_rel = fan_held_q & ~in_s1.fan_button_level;
		power_rel = power_held_q & ~in_s1.power_button_level;
		act_a = active_q;
		fan_a = fan_q;
		saved_a = fan_saved_q;
		fchg_a = 1'b0;
		if (fan_rel) begin
			act_a = 1'b1;
			fan_a = fan_step(fan_q);
			saved_a = fan_step(fan_q);
			fchg_a = 1'b1;
		end
		if (in_s1.remote_fan_valid) begin
			act_a = 1'b1;
			fan_a = (in_s1.remote_fan_speed > FAN_HIGH) ? FAN_HIGH : in_s1.remote_fan_speed;
			saved_a = fan_a;
			fchg_a = 1'b1;
		end
	end

	hvac_mode_eval u_power_eval (
		.active(1'b1),
		.mode_in(mode_q),
		.temp(temp_q),
		.target(target_q),
		.active_thr(active_thr_q),
		.inactive_thr(inactive_thr_q),
		.result(power_eval)
	);

	// power button
	always_comb begin
		act_b = act_a;
		fan_b = fan_a;
		mode_b = mode_q;
		fchg_b = fchg_a;
		mchg_b = 1'b0;
		if (power_rel) begin
			fchg_b = 1'b1;
			if (!act_a) begin
				act_b = 1'b1;
				fan_b = saved_a;
				mode_b = power_eval.mode;
				mchg_b = power_eval.changed;
			end else begin
				act_b = 1'b0;
				fan_b = FAN_OFF;
				mode_b = MODE_OFF;
				mchg_b = 1'b1;
			end
		end
	end

	assign temp_c = in_s1.sample_valid ? in_s1.sample_temperature : temp_q;

	hvac_mode_eval u_sample_eval (
		.active(act_b),
		.mode_in(mode_b),
		.temp(temp_c),
		.target(target_q),
		.active_thr(active_thr_q),
		.inactive_thr(inactive_thr_q),
		.result(sample_eval)
	);

	assign mode_c = in_s1.sample_valid ? sample_eval.mode : mode_b;
	assign mchg_c = mchg_b | (in_s1.sample_valid & sample_eval.changed);
	assign target_d = in_s1.setpoint_valid ? in_s1.setpoint_temperature : target_q;

	hvac_mode_eval u_setpoint_eval (
		.active(act_b),
		.mode_in(mode_c),
		.temp(temp_c),
		.target(target_d),
		.active_thr(active_thr_q),
		.inactive_thr(inactive_thr_q),
		.result(setpoint_eval)
	);

	assign mode_d = in_s1.setpoint_valid ? setpoint_eval.mode : mode_c;
	assign mchg_d = mchg_c | (in_s1.setpoint_valid & setpoint_eval.changed);

	// result of the pass
	always_comb begin
		if (!seeded_q) begin
			result_next.fan_speed = fan_q;
			result_next.system_on = active_q;
			result_next.climate_mode = mode_q;
			result_next.fan_changed = 1'b0;
			result_next.mode_changed = 1'b0;
			result_next.current_setpoint =
				in_s1.sample_valid ? in_s1.sample_temperature : target_q;
			result_next.current_temperature = temp_c;
		end else begin
			result_next.fan_speed = fan_b;
			result_next.system_on = act_b;
			result_next.climate_mode = mode_d;
			result_next.fan_changed = fchg_b;
			result_next.mode_changed = mchg_d;
			result_next.current_setpoint = target_d;
			result_next.current_temperature = temp_c;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_thr_q <= ACTIVE_THR_RESET;
			inactive_thr_q <= INACTIVE_THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE_THR: active_thr_q <= cfg_data;
				CFG_INACTIVE_THR: inactive_thr_q <= cfg_data;
				default: active_thr_q <= active_thr_q;
			endcase
		end
	end

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
		if (advance) begin
			out_q <= result_next;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			power_held_q <= 1'b0;
			fan_held_q <= 1'b0;
			fan_q <= FAN_OFF;
			fan_saved_q <= FAN_OFF;
			active_q <= 1'b0;
			mode_q <= MODE_OFF;
			target_q <= '0;
			temp_q <= '0;
		end else if (advance) begin
			seeded_q <= 1'b1;
			if (!seeded_q) begin
				if (in_s1.sample_valid) begin
					target_q <= in_s1.sample_temperature;
					temp_q <= in_s1.sample_temperature;
				end
			end else begin
				power_held_q <= in_s1.power_button_level;
				fan_held_q <= in_s1.fan_button_level;
				fan_q <= fan_b;
				fan_saved_q <= saved_a;
				active_q <= act_b;
				mode_q <= mode_d;
				target_q <= target_d;
				temp_q <= temp_c;
			end
		end
	end

endmodule
